FILE: sv/assert_macros.svh
// Assertion macros of the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define PVS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvs assertion failed");

// Next-cycle implication, quiet while reset is high
`define PVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvs assertion failed");

// Condition that must hold in the cycle after reset is seen
`define PVS_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("pvs reset assertion failed");

`endif

FILE: sv/pvs_pkg.sv
// Types and constants of the polyphonic voice synthesizer
`timescale 1ns / 1ps
`default_nettype none

package pvs_pkg;

  localparam int REQ_W    = 2;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int VOL_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 16;
  localparam int PHASE_W  = 32;
  localparam int NOTES    = 128;
  localparam int SEMITONES = 12;

  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ON      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_OFF     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ALL_OFF = 2'd3;

  localparam logic [VOL_W-1:0] VOL_RESET = 8'd77;

  localparam logic [15:0] SAW_WEIGHT  = 16'd22938;
  localparam logic [15:0] SINE_WEIGHT = 16'd9830;
  localparam logic [15:0] DECAY_Q16   = 16'd655;
  localparam logic [AMP_W-1:0] FREE_BELOW = 16'd66;
  localparam logic [7:0]  VEL_DIVISOR = 8'd127;
  localparam logic [7:0]  AMP_ROUND   = 8'd63;

  localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;

  // Q16 frequencies of notes 120 to 131
  localparam logic [31:0] TOP_OCTAVE_Q16 [SEMITONES] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
  };

endpackage

`default_nettype wire

FILE: sv/pvs_if.sv
// Request and sample channel interfaces of the voice synthesizer
`timescale 1ns / 1ps
`default_nettype none

interface pvs_req_if;
  logic                         valid;
  logic                         ready;
  logic [pvs_pkg::REQ_W-1:0]    req_type;
  logic [pvs_pkg::NOTE_W-1:0]   note;
  logic [pvs_pkg::VEL_W-1:0]    velocity;

  modport source (output valid, req_type, note, velocity, input ready);
  modport sink (input valid, req_type, note, velocity, output ready);
endinterface

interface pvs_smp_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvs_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

FILE: sv/polyphonic_voice_synth.sv
// Polyphonic phase-accumulator voice synthesizer, top level
`timescale 1ns / 1ps
`default_nettype none

// Takes one request at a time and is not ready while it works on it. Note off and all off
// finish on acceptance; note on goes through accept, one product of velocity and volume,
// folds of the base-128 digits of the scaled product and a final compare against 127;
// a dropped note on finishes on acceptance. A sample tick walks the voices with one
// shared 18x18 multiplier: an idle voice is only scanned, a sounding voice passes the
// scan, saw, sine, wave, multiply and accumulate states, a releasing voice adds the decay
// and release states, and the mix is then saturated and scaled, waiting while the output is full.
// The sample waits in an output register, so the next request is taken while it does.
// Sine and increment tables are built at elaboration and read through registered ports.
module polyphonic_voice_synth #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_RATE      = 44100,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pvs_pkg::VOL_W-1:0] cfg_data,
  pvs_req_if.sink                   request,
  pvs_smp_if.source                 audio
);

  localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SIDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PIDX_W  = pvs_pkg::PHASE_W + SIDX_W + 1;
  localparam int SUM_W   = 33 + $clog2(VOICES);
  localparam int FOLD_W  = pvs_pkg::VEL_W + 2 * pvs_pkg::VOL_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VMUL  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SAW   = 4'd4;
  localparam logic [3:0] S_SINE  = 4'd5;
  localparam logic [3:0] S_WAVE  = 4'd6;
  localparam logic [3:0] S_MAC   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_DEC   = 4'd9;
  localparam logic [3:0] S_DREL  = 4'd10;
  localparam logic [3:0] S_CLAMP = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  typedef logic signed [pvs_pkg::SAMPLE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [pvs_pkg::PHASE_W-1:0] incr_rom_t [pvs_pkg::NOTES];

  // sin(pi/2 * x) in Q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2, x3, x5, x7, x9, x11, pos, neg;
    x2  = (x * x) >> 30;
    x3  = (x2 * x) >> 30;
    x5  = (x3 * x2) >> 30;
    x7  = (x5 * x2) >> 30;
    x9  = (x7 * x2) >> 30;
    x11 = (x9 * x2) >> 30;
    pos = ((64'd1686629713 * x) >> 30) + ((64'd85569306 * x5) >> 30)
        + ((64'd172272 * x9) >> 30);
    neg = ((64'd693598669 * x3) >> 30) + ((64'd5026996 * x7) >> 30)
        + ((64'd3864 * x11) >> 30);
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] t, f, mag;
    logic [1:0]  quad;
    int          i;
    for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t    = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
      quad = t[31:30];
      f    = {34'd0, t[29:0]};
      if (quad[0]) begin
        f = pvs_pkg::Q30_ONE - f;
      end
      mag = (quarter_sine(f) * 64'd32767 + (pvs_pkg::Q30_ONE >> 1)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      rom[i] = quad[1] ? -16'(mag) : 16'(mag);
    end
    return rom;
  endfunction

  function automatic incr_rom_t build_incr();
    incr_rom_t   rom;
    logic [63:0] q;
    int          i, sh;
    for (i = 0; i < pvs_pkg::NOTES; i++) begin
      sh = 10 - i / pvs_pkg::SEMITONES;
      q  = (64'(pvs_pkg::TOP_OCTAVE_Q16[i % pvs_pkg::SEMITONES]) << 32)
         / 64'(SAMPLE_RATE);
      rom[i] = 32'((q + (64'd1 << (15 + sh))) >> (16 + sh));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam incr_rom_t INCR_ROM = build_incr();

  // Control state
  logic [3:0]                   state;
  logic [VOICES-1:0]            voice_active;
  logic [VOICES-1:0]            voice_releasing;
  logic [pvs_pkg::VOL_W-1:0]    master_volume;
  logic [VW-1:0]                vcnt;
  logic                         smp_valid;

  // Voice payload
  logic [pvs_pkg::NOTE_W-1:0]   voice_note      [VOICES];
  logic [pvs_pkg::PHASE_W-1:0]  voice_phase     [VOICES];
  logic [pvs_pkg::AMP_W-1:0]    voice_amplitude [VOICES];

  // Datapath registers
  logic [VW-1:0]                slot;
  logic [pvs_pkg::NOTE_W-1:0]   note_q;
  logic [pvs_pkg::VEL_W-1:0]    vel_q;
  logic [FOLD_W-1:0]            fold;
  logic [pvs_pkg::AMP_W-1:0]    quo;
  logic [SIDX_W-1:0]            sidx;
  logic signed [15:0]           sine_q;
  logic [pvs_pkg::PHASE_W-1:0]  incr_q;
  logic signed [35:0]           mul_p;
  logic signed [32:0]           wacc;
  logic signed [16:0]           wave;
  logic signed [SUM_W-1:0]      sum;
  logic [31:0]                  mag;
  logic                         neg;
  logic signed [pvs_pkg::SAMPLE_W-1:0] smp_data;

  // Combinational
  logic                         req_xfer, out_free, last_voice;
  logic signed [17:0]           mul_a, mul_b;
  logic signed [35:0]           mul_next;
  logic [pvs_pkg::PHASE_W-1:0]  ph_cur;
  logic [pvs_pkg::AMP_W-1:0]    amp_cur;
  logic signed [15:0]           saw;
  logic [PIDX_W-1:0]            idx_prod;
  logic [FOLD_W-8:0]            fold_hi;
  logic [6:0]                   fold_lo;
  logic                         fold_busy;
  logic [FOLD_W-1:0]            fold_next;
  logic [pvs_pkg::AMP_W-1:0]    quo_next, amp_new;
  logic signed [32:0]           wsum;
  logic [32:0]                  wabs, wrnd;
  logic signed [16:0]           wave_next;
  logic [26:0]                  dec_full;
  logic [pvs_pkg::AMP_W-1:0]    amp_dec;
  logic [SUM_W-1:0]             sabs;
  logic [46:0]                  scaled;
  logic [15:0]                  res;
  logic                         free_found;
  logic [VW-1:0]                free_slot;

  assign req_xfer      = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);
  assign out_free      = !smp_valid || audio.ready;
  assign audio.valid   = smp_valid;
  assign audio.sample  = smp_data;
  assign last_voice    = (vcnt == VW'(VOICES - 1));

  assign ph_cur   = voice_phase[vcnt];
  assign amp_cur  = voice_amplitude[vcnt];
  assign saw      = {~ph_cur[31], ph_cur[30:16]};
  assign idx_prod = PIDX_W'(ph_cur) * PIDX_W'(SINE_TABLE_DEPTH);

  // fold base-128 digits: x = 128a + b = 127a + (a + b)
  assign fold_hi   = fold[FOLD_W-1:7];
  assign fold_lo   = fold[6:0];
  assign fold_busy = |fold_hi;
  assign fold_next = FOLD_W'(fold_hi) + FOLD_W'(fold_lo);
  assign quo_next  = quo + fold_hi;
  assign amp_new   = quo + pvs_pkg::AMP_W'({1'b0, fold_lo} == pvs_pkg::VEL_DIVISOR);

  assign wsum      = wacc + signed'(mul_p[32:0]);
  assign wabs      = wsum[32] ? 33'(-wsum) : 33'(wsum);
  assign wrnd      = (wabs + 33'd16384) >> 15;
  assign wave_next = wsum[32] ? -signed'(wrnd[16:0]) : signed'(wrnd[16:0]);

  assign dec_full = mul_p[26:0] + 27'd32768;
  assign amp_dec  = amp_cur - {5'd0, dec_full[26:16]};

  assign sabs   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign scaled = {mag, 15'd0} - {15'd0, mag};
  assign res    = scaled[46:31];

  assign mul_next = mul_a * mul_b;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!voice_active[v]) begin
        free_found = 1'b1;
        free_slot  = VW'(v);
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_VMUL: begin
        mul_a = {11'd0, vel_q};
        mul_b = {10'd0, master_volume};
      end
      S_SAW: begin
        mul_a = {2'b00, pvs_pkg::SAW_WEIGHT};
        mul_b = {{2{saw[15]}}, saw};
      end
      S_SINE: begin
        mul_a = {2'b00, pvs_pkg::SINE_WEIGHT};
        mul_b = {{2{sine_q[15]}}, sine_q};
      end
      S_MAC: begin
        mul_a = {wave[16], wave};
        mul_b = {2'b00, amp_cur};
      end
      S_DEC: begin
        mul_a = {2'b00, amp_cur};
        mul_b = {2'b00, pvs_pkg::DECAY_Q16};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      voice_active    <= '0;
      voice_releasing <= '0;
      master_volume   <= pvs_pkg::VOL_RESET;
      vcnt            <= '0;
      smp_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        master_volume <= cfg_data;
      end
      if (state == S_OUT && out_free) begin
        smp_valid <= 1'b1;
      end else if (audio.ready) begin
        smp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            case (request.req_type)
              pvs_pkg::REQ_TICK: begin
                vcnt  <= '0;
                state <= S_SCAN;
              end
              pvs_pkg::REQ_ON: begin
                if (free_found) begin
                  state <= S_VMUL;
                end
              end
              pvs_pkg::REQ_OFF: begin
                for (int v = 0; v < VOICES; v++) begin
                  if (voice_active[v] && voice_note[v] == request.note) begin
                    voice_releasing[v] <= 1'b1;
                  end
                end
              end
              pvs_pkg::REQ_ALL_OFF: begin
                voice_active    <= '0;
                voice_releasing <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_VMUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!fold_busy) begin
            voice_active[slot]    <= 1'b1;
            voice_releasing[slot] <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (voice_active[vcnt]) begin
            state <= S_SAW;
          end else if (last_voice) begin
            state <= S_CLAMP;
          end else begin
            vcnt <= vcnt + VW'(1);
          end
        end
        S_SAW:  state <= S_SINE;
        S_SINE: state <= S_WAVE;
        S_WAVE: state <= S_MAC;
        S_MAC:  state <= S_ACC;
        S_ACC: begin
          if (voice_releasing[vcnt]) begin
            state <= S_DEC;
          end else if (last_voice) begin
            state <= S_CLAMP;
          end else begin
            vcnt  <= vcnt + VW'(1);
            state <= S_SCAN;
          end
        end
        S_DEC: state <= S_DREL;
        S_DREL: begin
          if (amp_dec < pvs_pkg::FREE_BELOW) begin
            voice_active[vcnt] <= 1'b0;
          end
          if (last_voice) begin
            state <= S_CLAMP;
          end else begin
            vcnt  <= vcnt + VW'(1);
            state <= S_SCAN;
          end
        end
        S_CLAMP: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p  <= mul_next;
    sidx   <= idx_prod[pvs_pkg::PHASE_W +: SIDX_W];
    sine_q <= SINE_ROM[sidx];
    incr_q <= INCR_ROM[voice_note[vcnt]];
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          note_q <= request.note;
          vel_q  <= request.velocity;
          slot   <= free_slot;
          sum    <= '0;
        end
      end
      S_VMUL: begin
        fold <= {mul_next[14:0], pvs_pkg::AMP_ROUND};
        quo  <= '0;
      end
      S_DIV: begin
        if (fold_busy) begin
          fold <= fold_next;
          quo  <= quo_next;
        end else begin
          voice_note[slot]      <= note_q;
          voice_phase[slot]     <= '0;
          voice_amplitude[slot] <= amp_new;
        end
      end
      S_SINE: wacc <= signed'(mul_p[32:0]);
      S_WAVE: begin
        wave              <= wave_next;
        voice_phase[vcnt] <= ph_cur + incr_q;
      end
      S_ACC: sum <= sum + {{(SUM_W-32){mul_p[31]}}, mul_p[31:0]};
      S_DREL: voice_amplitude[vcnt] <= amp_dec;
      S_CLAMP: begin
        neg <= sum[SUM_W-1];
        mag <= (sabs > SUM_W'(64'h8000_0000)) ? 32'h8000_0000 : sabs[31:0];
      end
      S_OUT: begin
        if (out_free) begin
          smp_data <= neg ? -signed'(res) : signed'(res);
        end
      end
      default: begin
        sum <= sum;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/pvs_checker.sv
// Port-level checker of the voice synthesizer and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pvs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic [pvs_pkg::REQ_W-1:0]           req_type,
  input logic                                smp_valid,
  input logic                                smp_ready,
  input logic signed [pvs_pkg::SAMPLE_W-1:0] sample
);

  `PVS_ASSERT_AFTER_RESET(a_no_sample_after_reset, clk, rst, !smp_valid)
  `PVS_ASSERT_NEXT(a_sample_held, clk, rst, smp_valid && !smp_ready, smp_valid)
  `PVS_ASSERT_NEXT(a_sample_stable, clk, rst, smp_valid && !smp_ready, $stable(sample))
  `PVS_ASSERT_NOW(a_sample_saturated, clk, rst, smp_valid, sample != 16'sh8000)
  `PVS_ASSERT_NEXT(a_tick_busy, clk, rst, req_valid && req_ready && req_type == pvs_pkg::REQ_TICK, !req_ready)

endmodule

bind polyphonic_voice_synth pvs_checker u_pvs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .req_type  (request.req_type),
  .smp_valid (audio.valid),
  .smp_ready (audio.ready),
  .sample    (audio.sample)
);

`default_nettype wire

FILE: tb/sample_checker.sv
// Checker for the voice synthesizer: tracks voice state and compares every mixed sample
`timescale 1ns / 1ps

module sample_checker #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_RATE      = 44100,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pvs_pkg::VOL_W-1:0] cfg_data,
  pvs_req_if                        request,
  pvs_smp_if                        audio,
  output int                        outstanding,
  output int                        failures
);

  typedef longint unsigned u64;

  logic [pvs_pkg::VOL_W-1:0]           volume;
  bit                                  sounding  [VOICES];
  bit                                  fading    [VOICES];
  logic [pvs_pkg::NOTE_W-1:0]          pitch     [VOICES];
  logic [pvs_pkg::PHASE_W-1:0]         phase_acc [VOICES];
  logic [pvs_pkg::AMP_W-1:0]           level     [VOICES];
  int                                  sine_lut  [SINE_TABLE_DEPTH];
  logic [pvs_pkg::PHASE_W-1:0]         step_lut  [pvs_pkg::NOTES];
  logic signed [pvs_pkg::SAMPLE_W-1:0] expected_samples [$];
  logic signed [pvs_pkg::SAMPLE_W-1:0] want;
  int                                  mismatches = 0;

  // sin(pi/2 * x), x and result in Q30
  function automatic u64 quarter_wave(u64 x);
    u64 x2, x3, x5, x7, x9, x11, pos, neg;
    x2  = (x * x) >> 30;
    x3  = (x2 * x) >> 30;
    x5  = (x3 * x2) >> 30;
    x7  = (x5 * x2) >> 30;
    x9  = (x7 * x2) >> 30;
    x11 = (x9 * x2) >> 30;
    pos = ((1686629713 * x) >> 30) + ((85569306 * x5) >> 30) + ((172272 * x9) >> 30);
    neg = ((693598669 * x3) >> 30) + ((5026996 * x7) >> 30) + ((3864 * x11) >> 30);
    return pos > neg ? pos - neg : 0;
  endfunction

  initial begin
    u64 turn, quad, frac, mag, q;
    int shift;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      turn = (u64'(i) << 32) / SINE_TABLE_DEPTH;
      quad = (turn >> 30) & 3;
      frac = turn & (pvs_pkg::Q30_ONE - 1);
      if (quad[0]) frac = pvs_pkg::Q30_ONE - frac;
      mag = (quarter_wave(frac) * 32767 + (pvs_pkg::Q30_ONE >> 1)) >> 30;
      if (mag > 32767) mag = 32767;
      sine_lut[i] = quad >= 2 ? -int'(mag) : int'(mag);
    end
    for (int n = 0; n < pvs_pkg::NOTES; n++) begin
      shift = 10 - n / pvs_pkg::SEMITONES;
      q = (u64'(pvs_pkg::TOP_OCTAVE_Q16[n % pvs_pkg::SEMITONES]) << 32) / SAMPLE_RATE;
      step_lut[n] = 32'((q + (u64'(1) << (15 + shift))) >> (16 + shift));
    end
  end

  function automatic logic signed [pvs_pkg::SAMPLE_W-1:0] render_sample();
    longint acc, saw, blend, wave;
    u64 idx, mag;
    int unsigned a;
    logic [pvs_pkg::PHASE_W-1:0] ph;
    acc = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (!sounding[v]) continue;
      ph    = phase_acc[v];
      idx   = (u64'(ph) * SINE_TABLE_DEPTH) >> 32;
      saw   = longint'(ph >> 16) - 32768;
      blend = longint'(pvs_pkg::SAW_WEIGHT) * saw
            + longint'(pvs_pkg::SINE_WEIGHT) * longint'(sine_lut[idx]);
      wave  = blend < 0 ? -((-blend + 16384) >>> 15) : (blend + 16384) >>> 15;
      acc  += wave * longint'(level[v]);
      phase_acc[v] = ph + step_lut[pitch[v]];
      if (fading[v]) begin
        a = level[v];
        a = a - ((a * pvs_pkg::DECAY_Q16 + 32768) >> 16);
        level[v] = 16'(a);
        if (a < pvs_pkg::FREE_BELOW) sounding[v] = 1'b0;
      end
    end
    mag = acc < 0 ? u64'(-acc) : u64'(acc);
    if (mag > (u64'(1) << 31)) mag = u64'(1) << 31;
    mag = (mag * 32767) >> 31;
    return acc < 0 ? -16'(mag) : 16'(mag);
  endfunction

  function automatic void claim_voice(logic [pvs_pkg::NOTE_W-1:0] key,
                                      logic [pvs_pkg::VEL_W-1:0] vel);
    for (int v = 0; v < VOICES; v++) begin
      if (!sounding[v]) begin
        pitch[v]     = key;
        phase_acc[v] = '0;
        level[v]     = 16'((int'(vel) * int'(volume) * 256 + int'(pvs_pkg::AMP_ROUND))
                           / int'(pvs_pkg::VEL_DIVISOR));
        fading[v]    = 1'b0;
        sounding[v]  = 1'b1;
        break;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      volume = pvs_pkg::VOL_RESET;
      for (int v = 0; v < VOICES; v++) begin
        sounding[v]  = 1'b0;
        fading[v]    = 1'b0;
        pitch[v]     = '0;
        phase_acc[v] = '0;
        level[v]     = '0;
      end
      expected_samples.delete();
    end else begin
      if (cfg_we) volume = cfg_data;
      if (audio.valid && audio.ready) begin
        if (expected_samples.size() == 0) begin
          if (mismatches < 10) $display("unexpected sample %0d", audio.sample);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (audio.sample !== want) begin
            if (mismatches < 10)
              $display("sample mismatch: expected %0d, got %0d", want, audio.sample);
            mismatches++;
          end
        end
      end
      if (request.valid && request.ready) begin
        case (request.req_type)
          pvs_pkg::REQ_TICK: expected_samples.push_back(render_sample());
          pvs_pkg::REQ_ON: claim_voice(request.note, request.velocity);
          pvs_pkg::REQ_OFF: begin
            for (int v = 0; v < VOICES; v++)
              if (sounding[v] && pitch[v] == request.note) fading[v] = 1'b1;
          end
          pvs_pkg::REQ_ALL_OFF: begin
            for (int v = 0; v < VOICES; v++) begin
              sounding[v] = 1'b0;
              fading[v]   = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_samples.size();
    failures    <= mismatches;
  end

endmodule

FILE: tb/testbench.sv
// Top of the voice synthesizer testbench: clock, reset, stimulus, sink and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int VOICES           = 8;
  localparam int SAMPLE_RATE      = 44100;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TAIL_CYCLES      = 80;
  localparam int LONG_HOLD        = 600;
  localparam int PHASE_ITEMS      = 285;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [pvs_pkg::VOL_W-1:0]  cfg_data;
  int                         outstanding;
  int                         failures;
  bit                         gaps_on   = 1'b1;
  bit                         stalls_on = 1'b1;
  logic [pvs_pkg::NOTE_W-1:0] held_notes [$];

  pvs_req_if req_ch ();
  pvs_smp_if smp_ch ();

  polyphonic_voice_synth #(
    .VOICES(VOICES), .SAMPLE_RATE(SAMPLE_RATE), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .request(req_ch), .audio(smp_ch)
  );

  sample_checker #(
    .VOICES(VOICES), .SAMPLE_RATE(SAMPLE_RATE), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) sample_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .request(req_ch), .audio(smp_ch), .outstanding(outstanding), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(logic [pvs_pkg::REQ_W-1:0] kind,
                              logic [pvs_pkg::NOTE_W-1:0] key,
                              logic [pvs_pkg::VEL_W-1:0] vel);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.note     <= key;
    req_ch.velocity <= vel;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_request();
    int pick, k;
    logic [pvs_pkg::NOTE_W-1:0] key;
    logic [pvs_pkg::VEL_W-1:0] vel;
    pick = $urandom_range(0, 99);
    key  = 7'($urandom);
    vel  = 7'($urandom);
    if (pick < 58) begin
      send_request(pvs_pkg::REQ_TICK, key, vel);
    end else if (pick < 78) begin
      if ($urandom_range(0, 3) == 0) vel = 7'($urandom_range(0, 8));
      if (held_notes.size() >= 24) void'(held_notes.pop_front());
      held_notes.push_back(key);
      send_request(pvs_pkg::REQ_ON, key, vel);
    end else if (pick < 97) begin
      if (held_notes.size() != 0 && $urandom_range(0, 3) != 0) begin
        k   = $urandom_range(0, held_notes.size() - 1);
        key = held_notes[k];
        held_notes.delete(k);
      end
      send_request(pvs_pkg::REQ_OFF, key, vel);
    end else begin
      held_notes.delete();
      send_request(pvs_pkg::REQ_ALL_OFF, key, vel);
    end
  endtask

  // sink side: random stalls, plus a long hold after the first and the 400th transfer
  initial begin
    int taken, run;
    bit hold_now;
    taken    = 0;
    run      = 0;
    hold_now = 1'b0;
    smp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_now) begin
        smp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_now = 1'b0;
      end else if (run == 0 && stalls_on && $urandom_range(0, 3) == 0) begin
        smp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        run = $urandom_range(1, 20);
      end else begin
        if (run == 0) run = $urandom_range(1, 20);
        smp_ch.ready <= 1'b1;
        @(posedge clk);
        run--;
        if (smp_ch.valid && smp_ch.ready) begin
          taken++;
          if (taken == 1 || taken == 400) hold_now = 1'b1;
        end
      end
    end
  end

  initial begin
    logic [pvs_pkg::VOL_W-1:0] plan [5];
    plan = '{8'd255, 8'd0, 8'd1, 8'd128, 8'($urandom_range(2, 254))};
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= pvs_pkg::REQ_TICK;
    req_ch.note     <= '0;
    req_ch.velocity <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset volume: silence, extremes, zero velocity, repeated release, full voices
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_ON, 7'd69, 7'd127);
    send_request(pvs_pkg::REQ_TICK, 7'd127, 7'd127);
    send_request(pvs_pkg::REQ_ON, 7'd0, 7'd127);
    send_request(pvs_pkg::REQ_ON, 7'd127, 7'd127);
    send_request(pvs_pkg::REQ_ON, 7'd60, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_OFF, 7'd69, 7'd0);
    send_request(pvs_pkg::REQ_OFF, 7'd69, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    for (int n = 50; n < 55; n++) send_request(pvs_pkg::REQ_ON, 7'(n), 7'd127);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_OFF, 7'd5, 7'd0);
    send_request(pvs_pkg::REQ_ALL_OFF, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_ON, 7'd100, 7'd1);
    send_request(pvs_pkg::REQ_OFF, 7'd100, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    send_request(pvs_pkg::REQ_TICK, 7'd0, 7'd0);
    settle();

    for (int p = 0; p < 5; p++) begin
      cfg_we   <= 1'b1;
      cfg_data <= plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      if (p == 4) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (PHASE_ITEMS) random_request();
      settle();
    end

    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
